### rtl/stb_pkg.sv
// Package for the software timer bank: item structs, codes and constants.
// Used by every module of the block; depends on nothing.
package stb_pkg;

  localparam int unsigned NS_PER_MS   = 1000000;
  localparam int unsigned NS_TICK_MAX = 100000000;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_CREATE  = 2'd1,
    CMD_DESTROY = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_TICK    = 2'd0,
    KIND_EXPIRY  = 2'd1,
    KIND_CREATE  = 2'd2,
    KIND_DESTROY = 2'd3
  } kind_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_WRONG_SRC = 3'd1;
  localparam logic [2:0] ST_NO_SLOT   = 3'd2;
  localparam logic [2:0] ST_ZERO_TO   = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  localparam logic CFG_NS_PER_TICK   = 1'b0;
  localparam logic CFG_ACTIVE_SOURCE = 1'b1;

  localparam logic [15:0] BAD_ID = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  source_id;
    logic [15:0] timer_id;
    logic [31:0] timeout_ms;
    logic        periodic;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] timer_ref;
    logic [2:0]  status;
    logic [6:0]  ms_advanced;
    logic [63:0] system_ms;
    logic [63:0] system_ticks;
    logic        last;
  } out_item_t;

  // Classified work passed from the front part to the back part.
  typedef struct packed {
    cmd_t        op;
    logic        src_ok;
    logic [26:0] ns_len;
    logic [15:0] timer_id;
    logic [31:0] timeout_ms;
    logic        periodic;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CONV,
    BK_SUMMARY,
    BK_WALK,
    BK_SEARCH,
    BK_REPLY
  } bk_state_t;

endpackage

### rtl/software_timer_bank.sv
// Top level of the software timer bank: config registers, front and back parts.
// Depends on stb_pkg, stb_front and stb_back.
//
//   channel  direction  handshake
//   in_      input      start and busy
//   out_     output     out_valid strobe, one cycle
//   cfg_     input      cfg_valid and cfg_ready
//
// A create (nonzero timeout) or destroy runs the slot search, stopping at the
// first free or matching slot. A tick runs carry conversion, one ms gained (up
// to 100) per step, then, if any ms was gained, the walk over all NUM_TIMERS
// slots. A two-entry job queue lets start be taken while the back part works.
// Reset is synchronous and clears all slots at once; results cannot be stalled.
module software_timer_bank
  import stb_pkg::*;
#(
  parameter int NUM_TIMERS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_valid,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  logic [26:0] ns_per_tick_r;
  logic [7:0]  active_source_r;
  logic        job_valid, job_take;
  job_t        job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ns_per_tick_r   <= 27'd1000000;
      active_source_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_NS_PER_TICK:   ns_per_tick_r   <= cfg_data[26:0];
        CFG_ACTIVE_SOURCE: active_source_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  stb_front u_front (
    .clk, .rst_n, .start, .busy, .in_item,
    .ns_per_tick(ns_per_tick_r), .active_source(active_source_r),
    .job_valid, .job, .job_take
  );

  stb_back #(.NUM_TIMERS(NUM_TIMERS)) u_back (
    .clk, .rst_n, .job_valid, .job, .job_take, .out_valid, .out_item
  );

endmodule

### rtl/stb_front.sv
// Front part: takes commands, checks source, clamps tick length, queues jobs.
// Depends on stb_pkg.
module stb_front
  import stb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  input  logic [26:0] ns_per_tick,
  input  logic [7:0]  active_source,
  output logic        job_valid,
  output job_t        job,
  input  logic        job_take
);

  logic [1:0] cnt_r, cnt_nxt;
  job_t       q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic       push;
  job_t       new_job;

  assign busy      = (cnt_r == 2'd2);
  assign push      = start && !busy && (in_item.command != CMD_NONE);
  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rd_ptr_r];

  always_comb begin
    new_job.op         = cmd_t'(in_item.command);
    new_job.src_ok     = (in_item.source_id == active_source);
    new_job.ns_len     = (ns_per_tick > 27'(NS_TICK_MAX)) ? 27'(NS_TICK_MAX) : ns_per_tick;
    new_job.timer_id   = in_item.timer_id;
    new_job.timeout_ms = in_item.timeout_ms;
    new_job.periodic   = in_item.periodic;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, job_take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (job_take) rd_ptr_r <= !rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= new_job;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("job queue count out of range");
  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    job_take |-> job_valid) else $error("job taken from empty queue");
  a_busy_full: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (cnt_r == 2'd2)) else $error("busy without full queue");

endmodule

### rtl/stb_back.sv
// Back part: time keeping, timer create and destroy, and the slot walk, one slot a cycle.
// Depends on stb_pkg.
module stb_back
  import stb_pkg::*;
#(
  parameter int NUM_TIMERS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_valid,
  input  job_t      job,
  output logic      job_take,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  bk_state_t   state_r, state_nxt;
  job_t        job_r;
  logic [IW:0] idx_r;
  logic [IW-1:0] ix;

  logic [NUM_TIMERS-1:0] used_r;
  logic [15:0] ident_r  [NUM_TIMERS];
  logic        per_r    [NUM_TIMERS];
  logic [31:0] period_r [NUM_TIMERS];
  logic [32:0] rem_r    [NUM_TIMERS];

  logic [27:0] sum_r;
  logic [6:0]  ms_r;
  logic [26:0] carry_r;
  logic [63:0] ms_cnt_r, tick_cnt_r;
  logic [15:0] next_id_r;
  logic        pend_r;
  logic        found_r;

  logic        walk_done, expire, match;
  logic [32:0] dec;
  logic        more_exp;

  assign ix  = idx_r[IW-1:0];
  assign dec = rem_r[ix] - {26'd0, ms_r};
  assign expire = used_r[ix] && ($signed(dec) <= 0);
  assign match  = used_r[ix] && (ident_r[ix] == job_r.timer_id);
  assign walk_done = (idx_r == (IW + 1)'(NUM_TIMERS - 1));

  always_comb begin
    more_exp = 1'b0;
    for (int j = 0; j < NUM_TIMERS; j++) begin
      if (j > int'(idx_r) && used_r[j] && ($signed(rem_r[j] - {26'd0, ms_r}) <= 0))
        more_exp = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (job_valid) begin
        unique case (job.op)
          CMD_TICK:    state_nxt = job.src_ok ? BK_CONV : BK_REPLY;
          CMD_CREATE:  state_nxt = (job.timeout_ms == '0) ? BK_REPLY : BK_SEARCH;
          CMD_DESTROY: state_nxt = BK_SEARCH;
          default:     state_nxt = BK_IDLE;
        endcase
      end
      BK_CONV:    if (sum_r < 28'(NS_PER_MS)) state_nxt = BK_SUMMARY;
      BK_SUMMARY: state_nxt = (ms_r != '0) ? BK_WALK : BK_IDLE;
      BK_WALK:    if (walk_done) state_nxt = BK_IDLE;
      BK_SEARCH:  if (walk_done || found_r) state_nxt = BK_REPLY;
      BK_REPLY:   state_nxt = BK_IDLE;
      default:    state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    job_take  = (state_r == BK_IDLE) && job_valid;
    out_valid = 1'b0;
    out_item  = '0;
    out_item.system_ms    = ms_cnt_r;
    out_item.system_ticks = tick_cnt_r;
    unique case (state_r)
      BK_SUMMARY: begin
        out_valid = 1'b1;
        out_item.kind = KIND_TICK;
        out_item.status = ST_OK;
        out_item.ms_advanced = ms_r;
        out_item.last = !pend_r;
      end
      BK_WALK: begin
        out_valid = expire;
        out_item.kind = KIND_EXPIRY;
        out_item.timer_ref = ident_r[ix];
        out_item.ms_advanced = ms_r;
        out_item.last = !more_exp;
      end
      BK_REPLY: begin
        out_valid = 1'b1;
        out_item.last = 1'b1;
        unique case (job_r.op)
          CMD_TICK: begin
            out_item.kind = KIND_TICK;
            out_item.status = ST_WRONG_SRC;
          end
          CMD_CREATE: begin
            out_item.kind = KIND_CREATE;
            if (job_r.timeout_ms == '0) begin
              out_item.status = ST_ZERO_TO;
              out_item.timer_ref = BAD_ID;
            end else if (!found_r) begin
              out_item.status = ST_NO_SLOT;
              out_item.timer_ref = BAD_ID;
            end else begin
              out_item.timer_ref = next_id_r - 16'd1;
            end
          end
          default: begin
            out_item.kind = KIND_DESTROY;
            out_item.timer_ref = job_r.timer_id;
            out_item.status = found_r ? ST_OK : ST_NOT_FOUND;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_IDLE;
      used_r     <= '0;
      carry_r    <= '0;
      ms_cnt_r   <= '0;
      tick_cnt_r <= '0;
      next_id_r  <= '0;
      idx_r      <= '0;
      found_r    <= 1'b0;
      pend_r     <= 1'b0;
      ms_r       <= '0;
      sum_r      <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        BK_IDLE: begin
          idx_r   <= '0;
          found_r <= 1'b0;
          ms_r    <= '0;
          sum_r   <= {1'b0, carry_r} + {1'b0, job.ns_len};
          if (job_valid && job.op == CMD_TICK && job.src_ok)
            tick_cnt_r <= tick_cnt_r + 64'd1;
        end
        BK_CONV: begin
          if (sum_r >= 28'(NS_PER_MS)) begin
            sum_r <= sum_r - 28'(NS_PER_MS);
            ms_r  <= ms_r + 7'd1;
          end else begin
            carry_r  <= sum_r[26:0];
            ms_cnt_r <= ms_cnt_r + {57'd0, ms_r};
            pend_r   <= 1'b0;
            for (int j = 0; j < NUM_TIMERS; j++) begin
              if (ms_r != '0 && used_r[j] && ($signed(rem_r[j] - {26'd0, ms_r}) <= 0))
                pend_r <= 1'b1;
            end
          end
        end
        BK_WALK: begin
          idx_r <= idx_r + 1'b1;
          if (used_r[ix]) begin
            if (expire && per_r[ix]) rem_r[ix] <= {1'b0, period_r[ix]};
            else rem_r[ix] <= dec;
            if (expire && !per_r[ix]) used_r[ix] <= 1'b0;
          end
        end
        BK_SEARCH: if (!found_r) begin
          idx_r <= idx_r + 1'b1;
          if (job_r.op == CMD_CREATE && !used_r[ix]) begin
            found_r       <= 1'b1;
            used_r[ix]    <= 1'b1;
            ident_r[ix]   <= next_id_r;
            per_r[ix]     <= job_r.periodic;
            period_r[ix]  <= job_r.timeout_ms;
            rem_r[ix]     <= {1'b0, job_r.timeout_ms};
            next_id_r     <= next_id_r + 16'd1;
          end else if (job_r.op == CMD_DESTROY && match) begin
            found_r    <= 1'b1;
            used_r[ix] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) job_r <= job;
  end

  a_walk_ms: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_WALK) |-> (ms_r != '0)) else $error("slot walk with no time gained");
  a_conv_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_SUMMARY) |-> (sum_r < 28'(NS_PER_MS))) else $error("carry not reduced");
  a_reply_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_REPLY) |=> (state_r == BK_IDLE)) else $error("reply lasted past one cycle");

endmodule
